@@ rtl/csw_pkg.sv @@
// Shared types, codes and constant functions for the soil water curve core.
`timescale 1ns / 1ps
`default_nettype none
package csw_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_CONTENT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KSAT        = 3'd4;

  localparam logic [15:0] SAT_CONTENT_RESET = 16'd29491;
  localparam logic [15:0] MULTIPLIER_RESET  = 16'd4096;
  localparam logic [15:0] SHAPE_RESET       = 16'd10240;
  localparam logic [31:0] ENTRY_RESET       = 32'hFFFF_7CEE;
  localparam logic [31:0] KSAT_RESET        = 32'd16777;

  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_ABOVE = 2'd2;

  // log2 unit: one normalize stage plus sixteen squaring stages
  localparam int LOG_LAT = 17;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_NEG,
    CLS_OVER,
    CLS_ZERO
  } cls_t;

  function automatic longint unsigned isqrt64(input longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    v   = val;
    res = 0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // k-th root of two in the chain 2^(2^-k), Q1.30
  function automatic logic [30:0] root_const(input int k);
    longint unsigned t;
    t = 64'd1 << 31;
    for (int j = 1; j <= 12; j++) begin
      if (j <= k) t = isqrt64(t << 30);
    end
    return t[30:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/csw_if.sv @@
// Channel interfaces: sample in, result out, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface csw_sample_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] water_content;
  logic               last_layer;
  modport source(output valid, water_content, last_layer, input ready);
  modport sink(input valid, water_content, last_layer, output ready);
endinterface

interface csw_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] matric_potential;
  logic        [31:0] conductivity;
  logic        [1:0]  status;
  logic               saturated;
  logic               last_layer_out;
  modport source(output valid, matric_potential, conductivity, status, saturated,
                 last_layer_out, input ready);
  modport sink(input valid, matric_potential, conductivity, status, saturated,
               last_layer_out, output ready);
endinterface

interface csw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/csw_delay.sv @@
// Stallable delay line for sideband bits that travel beside the datapath.
`timescale 1ns / 1ps
`default_nettype none
module csw_delay #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] line [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];
endmodule
`default_nettype wire

@@ rtl/csw_log2.sv @@
// Pipelined log2 of a 16-bit value, Q.16 result, one fraction bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module csw_log2 import csw_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x,
  output logic [19:0] y
);
  logic [3:0]  e_w;
  logic [30:0] m_w;
  logic [3:0]  ex [0:16];
  logic [30:0] m  [0:16];
  logic [15:0] fr [0:16];

  // normalize on the leading one; zero gives zero
  always_comb begin
    e_w = 4'd0;
    for (int j = 0; j < 16; j++) begin
      if (x[j]) e_w = 4'(j);
    end
    m_w = 31'(x) << (5'd30 - {1'b0, e_w});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex[0] <= e_w;
      m[0]  <= m_w;
      fr[0] <= '0;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] m2;
    assign sq = m[i] * m[i];
    assign m2 = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        ex[i+1] <= ex[i];
        m[i+1]  <= m2[31] ? m2[31:1] : m2[30:0];
        fr[i+1] <= {fr[i][14:0], m2[31]};
      end
    end
  end

  assign y = {ex[16], fr[16]};
endmodule
`default_nettype wire

@@ rtl/csw_pow2.sv @@
// Pipelined 2^(f/2^P) in Q1.30: one root-of-two factor per stage.
`timescale 1ns / 1ps
`default_nettype none
module csw_pow2 import csw_pkg::*; #(
  parameter int P = 8
) (
  input  logic         clk,
  input  logic         en,
  input  logic [P-1:0] f,
  output logic [30:0]  fac
);
  logic [30:0]  acc [1:P];
  logic [P-1:0] fb  [1:P];

  for (genvar k = 1; k <= P; k++) begin : g_stage
    localparam logic [30:0] C = root_const(k);
    logic [30:0]  a_in;
    logic [P-1:0] f_in;
    logic [61:0]  prod;
    if (k == 1) begin : g_first
      assign a_in = Q30_ONE;
      assign f_in = f;
    end else begin : g_rest
      assign a_in = acc[k-1];
      assign f_in = fb[k-1];
    end
    assign prod = a_in * C;
    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= f_in[P-k] ? prod[60:30] : a_in;
        fb[k]  <= f_in;
      end
    end
  end

  assign fac = acc[P];
endmodule
`default_nettype wire

@@ rtl/campbell_soil_water_curve_core.sv @@
// Throughput: one beat per cycle unless stalled; set by the 17-stage log2 pipeline and the
//   root-of-two chain of one multiply stage per table bit, both fully pipelined.
// A result beat held at the output stalls the whole pipe in place.
// Reset (synchronous) empties the pipe and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module campbell_soil_water_curve_core import csw_pkg::*; #(
  parameter int POW_TABLE_ADDR_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  csw_sample_if.sink   sample,
  csw_result_if.source result,
  csw_cfg_if.sink      cfg
);
  localparam int P = POW_TABLE_ADDR_BITS;

  logic [15:0] sat_content, multiplier, shape;
  logic [31:0] entry, ksat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_content <= SAT_CONTENT_RESET;
      multiplier  <= MULTIPLIER_RESET;
      shape       <= SHAPE_RESET;
      entry       <= ENTRY_RESET;
      ksat        <= KSAT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SAT_CONTENT: sat_content <= cfg.data[15:0];
        REG_MULTIPLIER:  multiplier  <= cfg.data[15:0];
        REG_SHAPE:       shape       <= cfg.data[15:0];
        REG_ENTRY:       entry       <= cfg.data;
        REG_KSAT:        ksat        <= cfg.data;
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  logic out_v;
  logic en;
  assign en           = !out_v || result.ready;
  assign sample.ready = en;

  // scale stage
  logic               a_v, a_last;
  logic signed [34:0] a_prod;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= sample.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= sample.water_content * $signed({1'b0, multiplier});
      a_last <= sample.last_layer;
    end
  end

  // truncate toward zero, classify the ratio
  logic signed [34:0] rnd;
  logic signed [21:0] scaled_w;
  cls_t               cls_w;
  always_comb begin
    rnd      = a_prod + (a_prod[34] ? 35'sd4095 : 35'sd0);
    scaled_w = rnd[33:12];
    if (scaled_w[21]) cls_w = CLS_NEG;
    else if (scaled_w > $signed({6'b0, sat_content})) cls_w = CLS_OVER;
    else if (scaled_w == 22'sd0 && sat_content != 16'd0) cls_w = CLS_ZERO;
    else cls_w = CLS_NORMAL;
  end

  logic        b_v, b_last;
  cls_t        b_cls;
  logic [15:0] b_scaled;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v   <= 1'b0;
      b_cls <= CLS_NORMAL;
    end else if (en) begin
      b_v   <= a_v;
      b_cls <= cls_w;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_last   <= a_last;
      b_scaled <= scaled_w[15:0];
    end
  end

  logic [19:0] lsat, lval;
  csw_log2 u_log_sat (.clk(clk), .en(en), .x(sat_content), .y(lsat));
  csw_log2 u_log_val (.clk(clk), .en(en), .x(b_scaled), .y(lval));

  // log ratio; a negative ratio or a zero saturation content gives zero
  logic [20:0] diff;
  logic [19:0] nl;
  assign diff = {1'b0, lsat} - {1'b0, lval};
  always_ff @(posedge clk) begin
    if (en) nl <= (diff[20] || sat_content == 16'd0) ? 20'd0 : diff[19:0];
  end

  // exponent products, split into shift count and table fraction
  logic [35:0]  a_p;
  logic [37:0]  a_c;
  logic [17:0]  cexp;
  logic [8:0]   q_np;
  logic [10:0]  q_nc;
  logic [P-1:0] q_fp, q_fc, fc_inv;
  assign cexp = {1'b0, shape, 1'b0} + 18'd6144;
  assign a_p  = shape * nl;
  assign a_c  = cexp * nl;
  always_ff @(posedge clk) begin
    if (en) begin
      q_np <= a_p[35:27];
      q_fp <= a_p[26:27-P];
      q_nc <= a_c[37:27];
      q_fc <= a_c[26:27-P];
    end
  end
  // 2^P - f; zero stays zero, which selects the unit factor
  assign fc_inv = ~q_fc + 1'b1;

  logic [30:0] fac_p, fac_c;
  csw_pow2 #(.P(P)) u_pow_pot  (.clk(clk), .en(en), .f(q_fp),   .fac(fac_p));
  csw_pow2 #(.P(P)) u_pow_cond (.clk(clk), .en(en), .f(fc_inv), .fac(fac_c));

  logic [20:0] d_n;
  csw_delay #(.WIDTH(21), .DEPTH(P + 1)) u_dly_n (
    .clk(clk), .rst(rst), .en(en),
    .din({q_np, q_nc, (q_fc == '0)}), .dout(d_n)
  );

  logic [3:0] d_s;
  csw_delay #(.WIDTH(4), .DEPTH(LOG_LAT + P + 3)) u_dly_s (
    .clk(clk), .rst(rst), .en(en),
    .din({b_v, b_cls, b_last}), .dout(d_s)
  );

  logic        neg;
  logic [31:0] emag;
  logic [47:0] limit;
  assign neg   = entry[31];
  assign emag  = neg ? (~entry + 32'd1) : entry;
  assign limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;

  logic [62:0] mag_p, mag_c;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_p <= emag * fac_p;
      mag_c <= ksat * fac_c;
    end
  end

  logic        dv, dlast, fz;
  cls_t        dcls;
  logic [8:0]  np, s;
  logic [10:0] nc;
  logic [11:0] sh;
  logic [62:0] shr, shc;
  logic [47:0] pot_mag, pm;
  logic        pot_clamp, clamp_w;
  logic [31:0] cond_w;
  logic [1:0]  status_w;

  always_comb begin
    {np, nc, fz}       = d_n;
    dv                 = d_s[3];
    dcls               = cls_t'(d_s[2:1]);
    dlast              = d_s[0];
    pot_mag            = '0;
    pot_clamp          = 1'b0;
    shr                = '0;
    s                  = '0;
    if (np < 9'd30) begin
      shr = mag_p >> (6'd30 - {1'b0, np[4:0]});
      if (shr > {15'b0, limit}) pot_clamp = 1'b1;
      else pot_mag = shr[47:0];
    end else begin
      s = np - 9'd30;
      if (mag_p == 63'd0) pot_mag = '0;
      else if (s >= 9'd48 || mag_p > {15'b0, limit >> s[5:0]}) pot_clamp = 1'b1;
      else pot_mag = mag_p[47:0] << s[5:0];
    end
    if (pot_clamp) pot_mag = limit;

    sh  = {1'b0, nc} + (fz ? 12'd30 : 12'd31);
    shc = mag_c >> sh[5:0];
    cond_w = (sh >= 12'd64) ? 32'd0 : shc[31:0];

    pm       = '0;
    clamp_w  = 1'b0;
    status_w = STATUS_VALID;
    case (dcls)
      CLS_NEG:  begin
        status_w = STATUS_BELOW;
        cond_w   = '0;
      end
      CLS_OVER: begin
        status_w = STATUS_ABOVE;
        cond_w   = '0;
      end
      CLS_ZERO: begin
        cond_w = '0;
        if (shape == 16'd0) begin
          pm = {16'b0, emag};
        end else if (emag != 32'd0) begin
          pm      = limit;
          clamp_w = 1'b1;
        end
      end
      default: begin
        pm      = pot_mag;
        clamp_w = pot_clamp;
      end
    endcase
  end

  logic signed [47:0] pot_q;
  logic        [31:0] cond_q;
  logic        [1:0]  status_q;
  logic               sat_q, last_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pot_q    <= neg ? $signed(~pm + 48'd1) : $signed(pm);
      cond_q   <= cond_w;
      status_q <= status_w;
      sat_q    <= clamp_w;
      last_q   <= dlast;
    end
  end

  assign result.valid            = out_v;
  assign result.matric_potential = pot_q;
  assign result.conductivity     = cond_q;
  assign result.status           = status_q;
  assign result.saturated        = sat_q;
  assign result.last_layer_out   = last_q;
endmodule
`default_nettype wire

@@ rtl/csw_checker.sv @@
// Port-level assertions for the soil water curve core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csw_checker import csw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  status,
  input logic [47:0] matric_potential,
  input logic [31:0] conductivity,
  input logic        saturated
);
  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(matric_potential) && $stable(status))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    valid && status != STATUS_VALID |->
      matric_potential == 48'd0 && conductivity == 32'd0 && !saturated)
    else $error("error status with nonzero results");

  a_status: assert property (@(posedge clk) disable iff (rst)
    valid |-> status == STATUS_VALID || status == STATUS_BELOW || status == STATUS_ABOVE)
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");
endmodule

bind campbell_soil_water_curve_core csw_checker u_csw_checker (
  .clk(clk),
  .rst(rst),
  .valid(result.valid),
  .ready(result.ready),
  .status(result.status),
  .matric_potential(result.matric_potential),
  .conductivity(result.conductivity),
  .saturated(result.saturated)
);
`default_nettype wire
